FILE: sv/sha_pkg.sv
// ============================================================================
// SHA-256 package
// Shared types, constants and round functions for the byte-stream hash.
// ============================================================================
package sha_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } sha_in_t;

  typedef struct packed {
    logic [31:0] digest_word_0;
    logic [31:0] digest_word_1;
    logic [31:0] digest_word_2;
    logic [31:0] digest_word_3;
    logic [31:0] digest_word_4;
    logic [31:0] digest_word_5;
    logic [31:0] digest_word_6;
    logic [31:0] digest_word_7;
  } sha_out_t;

  // Queue entry between front and back: one block byte plus control.
  typedef struct packed {
    logic [7:0] data;
    logic       last_blk;  // byte completes a block
    logic       last_msg;  // block is the final one of the message
  } sha_tok_t;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_PAD,
    FE_LEN
  } sha_fe_state_e;

  typedef enum logic [1:0] {
    BE_FILL,
    BE_ROUND,
    BE_ADD,
    BE_OUT
  } sha_be_state_e;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = 2;
  localparam logic [7:0]  PadByte = 8'h80;
  localparam logic [5:0]  LenOffset = 6'd56;

  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] sig0(input logic [31:0] x);
    sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sig1(input logic [31:0] x);
    sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage

FILE: sv/sha_front.sv
// ============================================================================
// SHA-256 front end
// Accepts requests, counts bytes and emits the padded byte stream as tokens.
// ============================================================================
module sha_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  sha_pkg::sha_in_t in_data_i,
  output logic             tok_valid_o,
  input  logic             tok_ready_i,
  output sha_pkg::sha_tok_t tok_o
);
  import sha_pkg::*;

  sha_fe_state_e state_q, state_d;
  logic [5:0]  fill_q, fill_d;
  logic [63:0] total_q, total_d;
  logic [63:0] bits_q, bits_d;
  logic [2:0]  len_idx_q, len_idx_d;
  logic        pad_first_q, pad_first_d;
  logic        tok_adv;

  assign tok_adv = tok_valid_o && tok_ready_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FE_IDLE: begin
        if (in_valid_i && in_ready_o && in_data_i.end_of_message) state_d = FE_PAD;
      end
      FE_PAD: begin
        if (tok_adv && (fill_q + 6'd1) == LenOffset) state_d = FE_LEN;
      end
      FE_LEN: begin
        if (tok_adv && len_idx_q == 3'd7) state_d = FE_IDLE;
      end
      default: state_d = FE_IDLE;
    endcase
  end

  // Outputs and datapath.
  always_comb begin
    in_ready_o  = 1'b0;
    tok_valid_o = 1'b0;
    tok_o       = '0;
    fill_d      = fill_q;
    total_d     = total_q;
    bits_d      = bits_q;
    len_idx_d   = len_idx_q;
    pad_first_d = pad_first_q;
    unique case (state_q)
      FE_IDLE: begin
        tok_o.data     = in_data_i.data_byte;
        tok_o.last_blk = (fill_q == 6'd63);
        tok_valid_o    = in_valid_i && in_data_i.byte_present;
        in_ready_o     = !in_data_i.byte_present || tok_ready_i;
        if (in_valid_i && in_ready_o) begin
          if (in_data_i.byte_present) begin
            fill_d  = fill_q + 6'd1;
            total_d = total_q + 64'd1;
          end
          if (in_data_i.end_of_message) begin
            bits_d      = (in_data_i.byte_present ? total_q + 64'd1 : total_q) << 3;
            pad_first_d = 1'b1;
            len_idx_d   = '0;
          end
        end
      end
      FE_PAD: begin
        // Emit 0x80, then zeros until the length field at offset 56.
        tok_valid_o    = 1'b1;
        tok_o.data     = pad_first_q ? PadByte : 8'h00;
        tok_o.last_blk = (fill_q == 6'd63);
        if (tok_adv) begin
          fill_d      = fill_q + 6'd1;
          pad_first_d = 1'b0;
        end
      end
      FE_LEN: begin
        tok_valid_o    = 1'b1;
        tok_o.data     = bits_q[63 - 8*len_idx_q -: 8];
        tok_o.last_blk = (len_idx_q == 3'd7);
        tok_o.last_msg = (len_idx_q == 3'd7);
        if (tok_adv) begin
          len_idx_d = len_idx_q + 3'd1;
          fill_d    = fill_q + 6'd1;
          if (len_idx_q == 3'd7) begin
            total_d = '0;
            fill_d  = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FE_IDLE;
      fill_q      <= '0;
      total_q     <= '0;
      len_idx_q   <= '0;
      pad_first_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      total_q     <= total_d;
      len_idx_q   <= len_idx_d;
      pad_first_q <= pad_first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bits_q <= bits_d;
  end

`ifndef ASSERT_OFF
  a_len_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FE_LEN) |-> (fill_q == LenOffset + {3'd0, len_idx_q}))
    else $error("length bytes off alignment");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != FE_IDLE) |-> !in_ready_o)
    else $error("request taken while padding");
  a_last_msg_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tok_adv && tok_o.last_msg) |=> (state_q == FE_IDLE && fill_q == '0))
    else $error("message end left state");
`endif

endmodule

FILE: sv/sha_queue.sv
// ============================================================================
// SHA-256 token queue
// Small FIFO decoupling the front end from the compression core.
// ============================================================================
module sha_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_valid_i,
  output logic              wr_ready_o,
  input  sha_pkg::sha_tok_t wr_data_i,
  output logic              rd_valid_o,
  input  logic              rd_ready_i,
  output sha_pkg::sha_tok_t rd_data_o
);
  import sha_pkg::*;

  sha_tok_t        mem_q [QDepth];
  logic [QAw-1:0]  wp_q, rp_q;
  logic [QAw:0]    cnt_q;
  logic            push, pop;

  assign wr_ready_o = (cnt_q != (QAw+1)'(QDepth));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rp_q];
  assign push = wr_valid_i && wr_ready_o;
  assign pop  = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= wp_q + QAw'(1);
      if (pop)  rp_q <= rp_q + QAw'(1);
      cnt_q <= cnt_q + {{QAw{1'b0}}, push} - {{QAw{1'b0}}, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= wr_data_i;
  end

endmodule

FILE: sv/sha_core.sv
// ============================================================================
// SHA-256 compression core
// Collects 64 block bytes into a 16-word window and runs 64 rounds.
// ============================================================================
module sha_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              tok_valid_i,
  output logic              tok_ready_o,
  input  sha_pkg::sha_tok_t tok_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output sha_pkg::sha_out_t out_data_o
);
  import sha_pkg::*;

  sha_be_state_e state_q, state_d;
  logic [31:0] w_q [16];
  logic [31:0] h_q [8];
  logic [31:0] v_q [8];
  logic [5:0]  rnd_q;
  logic        last_q;
  logic [1:0]  bpos_q;
  logic [31:0] w_new, t1, t2;
  logic        tok_adv;

  assign tok_adv = tok_valid_i && tok_ready_o;
  assign w_new = sig1(w_q[14]) + w_q[9] + sig0(w_q[1]) + w_q[0];
  assign t1 = v_q[7] + bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
            + RoundK[rnd_q] + w_q[0];
  assign t2 = bsig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BE_FILL:  if (tok_adv && tok_i.last_blk) state_d = BE_ROUND;
      BE_ROUND: if (rnd_q == 6'd63) state_d = BE_ADD;
      BE_ADD:   state_d = last_q ? BE_OUT : BE_FILL;
      BE_OUT:   if (out_ready_i) state_d = BE_FILL;
      default:  state_d = BE_FILL;
    endcase
  end

  always_comb begin
    tok_ready_o = (state_q == BE_FILL);
    out_valid_o = (state_q == BE_OUT);
    out_data_o = '{h_q[0], h_q[1], h_q[2], h_q[3], h_q[4], h_q[5], h_q[6], h_q[7]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BE_FILL;
      rnd_q   <= '0;
      last_q  <= 1'b0;
      for (int i = 0; i < 8; i++) h_q[i] <= InitHash[i];
    end else begin
      state_q <= state_d;
      if (tok_adv && tok_i.last_blk) last_q <= tok_i.last_msg;
      if (state_q == BE_ROUND) rnd_q <= rnd_q + 6'd1;
      if (state_q == BE_ADD) begin
        for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
      end
      if (state_q == BE_OUT && out_ready_i) begin
        for (int i = 0; i < 8; i++) h_q[i] <= InitHash[i];
      end
    end
  end

  // Byte counter inside the word: shift the window on every fourth byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) bpos_q <= '0;
    else if (tok_adv) bpos_q <= bpos_q + 2'd1;
  end

  // Window shifts bytes in while filling and one word per round after.
  always_ff @(posedge clk_i) begin
    if (state_q == BE_FILL && tok_adv) begin
      if (bpos_q == 2'd0) begin
        for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      end
      w_q[15] <= {w_q[15][23:0], tok_i.data};
      for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
    end
    if (state_q == BE_ROUND) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= w_new;
      v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

`ifndef ASSERT_OFF
  a_rnd_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BE_FILL) |-> (rnd_q == '0))
    else $error("round counter not cleared");
  a_blk_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tok_adv && tok_i.last_blk) |-> (bpos_q == 2'd3))
    else $error("block ends mid-word");
  a_out_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(last_q))
    else $error("digest without final block");
`endif

endmodule

FILE: sv/sha256_byte_stream_hash.sv
// ============================================================================
// SHA-256 byte-stream hash
// Hashes a byte stream and returns a 256-bit digest per message.
// ============================================================================
//  channel | dir | payload                 | handshake
//  in      | in  | sha_in_t  (byte, flags) | in_valid_i / in_ready_o
//  out     | out | sha_out_t (8 words)     | out_valid_o / out_ready_i
//
//  Each byte becomes one token at the front; each full block then runs
//  64 rounds and one add in the core, so throughput is set by the single
//  round unit. End of message adds 9 to 72 padding bytes at one per
//  cycle while the queue has room.
//  Reset (rst_ni low) restores the initial hash and empties the queue.
//  Either side may stall; the token queue absorbs up to four bytes.
module sha256_byte_stream_hash (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sha_pkg::sha_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output sha_pkg::sha_out_t out_data_o
);
  import sha_pkg::*;

  sha_tok_t f_tok, c_tok;
  logic     f_valid, f_ready, c_valid, c_ready;

  // Classify requests and produce padded bytes.
  sha_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .tok_valid_o(f_valid), .tok_ready_i(f_ready), .tok_o(f_tok));

  // Hold bytes while the core is busy with rounds.
  sha_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(f_valid), .wr_ready_o(f_ready), .wr_data_i(f_tok),
    .rd_valid_o(c_valid), .rd_ready_i(c_ready), .rd_data_o(c_tok));

  // Compress blocks and present the digest.
  sha_core u_core (
    .clk_i, .rst_ni,
    .tok_valid_i(c_valid), .tok_ready_o(c_ready), .tok_i(c_tok),
    .out_valid_o, .out_ready_i, .out_data_o);

endmodule
